### rtl/core/dcsd_pkg.sv
// ----------------------------------------------------------------------------
// Diff command stream decoder package
// Shared types, character codes and result builders for the decoder.
// ----------------------------------------------------------------------------
package dcsd_pkg;

  localparam int CountWidth = 32;
  localparam int EffWidth   = (CountWidth < 32) ? CountWidth : 32;
  localparam int ProdWidth  = 36;
  localparam logic [ProdWidth-1:0] CountLim =
      (ProdWidth'(1) << EffWidth) - ProdWidth'(1);

  localparam int QueueDepth = 4;
  localparam int QueueIdxW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] KindLiteral = 2'd0;
  localparam logic [1:0] KindCopy    = 2'd1;
  localparam logic [1:0] KindEnd     = 2'd2;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeALen    = 3'd1,
    ModeAData   = 3'd2,
    ModeCLen    = 3'd3,
    ModeCOff    = 3'd4,
    ModeDiscard = 3'd5
  } mode_e;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  literal_byte;
    logic [31:0] copy_length;
    logic [31:0] copy_offset;
    logic        end_ok;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res1;
    res_t       res0;
  } push_t;

  function automatic logic [ProdWidth-1:0] times_ten_plus(logic [31:0] v, logic [3:0] d);
    logic [ProdWidth-1:0] w;
    w = {4'b0, v};
    return (w << 3) + (w << 1) + {32'b0, d};
  endfunction

  function automatic res_t mk_literal(logic [7:0] b);
    res_t r;
    r = '0;
    r.result_kind  = KindLiteral;
    r.literal_byte = b;
    return r;
  endfunction

  function automatic res_t mk_copy(logic [31:0] len, logic [31:0] off);
    res_t r;
    r = '0;
    r.result_kind = KindCopy;
    r.copy_length = len;
    r.copy_offset = off;
    return r;
  endfunction

  function automatic res_t mk_end(logic ok);
    res_t r;
    r = '0;
    r.result_kind = KindEnd;
    r.end_ok      = ok;
    return r;
  endfunction

endpackage

### rtl/core/dcsd_if.sv
// ----------------------------------------------------------------------------
// Diff command stream decoder channels
// Valid/ready channel interfaces for script bytes and decoded results.
// ----------------------------------------------------------------------------
interface dcsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       final_byte;

  modport source (output valid, output script_byte, output final_byte, input ready);
  modport sink (input valid, input script_byte, input final_byte, output ready);
endinterface

interface dcsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  literal_byte;
  logic [31:0] copy_length;
  logic [31:0] copy_offset;
  logic        end_ok;
  logic        run_last;

  modport source (output valid, output result_kind, output literal_byte, output copy_length,
                  output copy_offset, output end_ok, output run_last, input ready);
  modport sink (input valid, input result_kind, input literal_byte, input copy_length,
                input copy_offset, input end_ok, input run_last, output ready);
endinterface

### rtl/core/dcsd_parser.sv
// ----------------------------------------------------------------------------
// Diff command stream decoder parser
// Holds the parse state and turns one script byte into up to two results.
// ----------------------------------------------------------------------------
module dcsd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                final_i,
  output dcsd_pkg::push_t     push_o
);

  dcsd_pkg::mode_e mode_q, mode_d;
  logic [31:0] len_q, len_d;
  logic [31:0] off_q, off_d;

  logic                           dig;
  logic [3:0]                     dval;
  logic [dcsd_pkg::ProdWidth-1:0] len_next;
  logic [dcsd_pkg::ProdWidth-1:0] off_next;
  logic                           take_cmd;
  logic                           err;
  logic                           skip;
  logic [1:0]                     n;
  dcsd_pkg::res_t                 res [2];

  assign dig      = (byte_i >= dcsd_pkg::ChZero) && (byte_i <= dcsd_pkg::ChNine);
  assign dval     = 4'(byte_i - dcsd_pkg::ChZero);
  assign len_next = dcsd_pkg::times_ten_plus(len_q, dval);
  assign off_next = dcsd_pkg::times_ten_plus(off_q, dval);

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    off_d    = off_q;
    take_cmd = 1'b0;
    err      = 1'b0;
    skip     = 1'b0;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;

    case (mode_q)
      dcsd_pkg::ModeDiscard: begin
        skip = 1'b1;
        if (final_i) begin
          mode_d = dcsd_pkg::ModeIdle;
        end
      end
      dcsd_pkg::ModeALen: begin
        if (dig) begin
          if (len_next > dcsd_pkg::CountLim) err = 1'b1;
          else len_d = len_next[31:0];
        end else if (byte_i == dcsd_pkg::ChColon) begin
          mode_d = (len_q == '0) ? dcsd_pkg::ModeIdle : dcsd_pkg::ModeAData;
        end else begin
          err = 1'b1;
        end
      end
      dcsd_pkg::ModeAData: begin
        res[0] = dcsd_pkg::mk_literal(byte_i);
        n      = 2'd1;
        len_d  = len_q - 32'd1;
        if (len_q == 32'd1) begin
          mode_d = dcsd_pkg::ModeIdle;
        end
      end
      dcsd_pkg::ModeCLen: begin
        if (dig) begin
          if (len_next > dcsd_pkg::CountLim) err = 1'b1;
          else len_d = len_next[31:0];
        end else if (byte_i == dcsd_pkg::ChComma) begin
          off_d  = '0;
          mode_d = dcsd_pkg::ModeCOff;
        end else begin
          err = 1'b1;
        end
      end
      dcsd_pkg::ModeCOff: begin
        if (dig) begin
          if (off_next > dcsd_pkg::CountLim) err = 1'b1;
          else off_d = off_next[31:0];
        end else begin
          res[0]   = dcsd_pkg::mk_copy(len_q, off_q);
          n        = 2'd1;
          mode_d   = dcsd_pkg::ModeIdle;
          take_cmd = 1'b1;
        end
      end
      default: begin
        mode_d   = dcsd_pkg::ModeIdle;
        take_cmd = 1'b1;
      end
    endcase

    if (take_cmd) begin
      if (byte_i == dcsd_pkg::ChA) begin
        len_d  = '0;
        mode_d = dcsd_pkg::ModeALen;
      end else if (byte_i == dcsd_pkg::ChC) begin
        len_d  = '0;
        off_d  = '0;
        mode_d = dcsd_pkg::ModeCLen;
      end else if (byte_i != dcsd_pkg::ChLf && byte_i != dcsd_pkg::ChCr) begin
        err = 1'b1;
      end
    end

    if (!skip) begin
      if (err) begin
        res[n[0]] = dcsd_pkg::mk_end(1'b0);
        n         = n + 2'd1;
        mode_d    = final_i ? dcsd_pkg::ModeIdle : dcsd_pkg::ModeDiscard;
        len_d     = '0;
        off_d     = '0;
      end else if (final_i) begin
        if (mode_d == dcsd_pkg::ModeCOff) begin
          res[0] = dcsd_pkg::mk_copy(len_d, off_d);
          res[1] = dcsd_pkg::mk_end(1'b1);
          n      = 2'd2;
        end else begin
          res[n[0]] = dcsd_pkg::mk_end(mode_d == dcsd_pkg::ModeIdle);
          n         = n + 2'd1;
        end
        mode_d = dcsd_pkg::ModeIdle;
        len_d  = '0;
        off_d  = '0;
      end
    end

    if (n == 2'd1) res[0].run_last = 1'b1;
    if (n == 2'd2) res[1].run_last = 1'b1;
  end

  assign push_o.count = step_i ? n : 2'd0;
  assign push_o.res0  = res[0];
  assign push_o.res1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dcsd_pkg::ModeIdle;
      len_q  <= '0;
      off_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      off_q  <= off_d;
    end
  end

endmodule

### rtl/core/dcsd_queue.sv
// ----------------------------------------------------------------------------
// Diff command stream decoder result queue
// Small register queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module dcsd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dcsd_pkg::push_t  push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output dcsd_pkg::res_t   res_o
);

  dcsd_pkg::res_t mem_q [dcsd_pkg::QueueDepth];

  logic [dcsd_pkg::QueueIdxW-1:0] head_q, head_d;
  logic [dcsd_pkg::QueueIdxW-1:0] tail_q, tail_d;
  logic [dcsd_pkg::QueueIdxW-1:0] tail_nx;
  logic [dcsd_pkg::QueueCntW-1:0] count_q, count_d;
  logic                           pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[head_q];
  assign room_o  = (count_q <= dcsd_pkg::QueueCntW'(dcsd_pkg::QueueDepth - 2));
  assign tail_nx = tail_q + dcsd_pkg::QueueIdxW'(1);

  always_comb begin
    head_d  = pop ? head_q + dcsd_pkg::QueueIdxW'(1) : head_q;
    tail_d  = tail_q + dcsd_pkg::QueueIdxW'(push_i.count);
    count_d = count_q + dcsd_pkg::QueueCntW'(push_i.count) - dcsd_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[tail_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[tail_nx] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dcsd_pkg::QueueCntW'(dcsd_pkg::QueueDepth))
    else $error("Result queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("Results pushed while the queue lacks room.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |=> valid_o)
    else $error("Queue empty right after a push.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("Empty queue with head and tail apart.");

endmodule

### rtl/core/diff_command_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Diff command stream decoder top level
// A transferred byte is registered; the parser then writes its results into the result queue, which offers them.
// Throughput: one byte per cycle while the result queue has room; results leave the queue one at a time.
// The parser runs once the result queue has room for two entries.
// Reset: asynchronous and active low; the parser returns to idle and queues empty.
// ----------------------------------------------------------------------------
module diff_command_stream_decoder_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  dcsd_in_if.sink    in_i,
  dcsd_out_if.source out_o
);

  logic             vld_q;
  logic [7:0]       byte_q;
  logic             fin_q;
  logic             room;
  logic             step;
  dcsd_pkg::push_t  push;
  dcsd_pkg::res_t   res;

  assign step     = vld_q && room;
  assign in_i.ready = !vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.script_byte;
      fin_q  <= in_i.final_byte;
    end
  end

  dcsd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (byte_q),
    .final_i (fin_q),
    .push_o  (push)
  );

  dcsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.result_kind  = res.result_kind;
  assign out_o.literal_byte = res.literal_byte;
  assign out_o.copy_length  = res.copy_length;
  assign out_o.copy_offset  = res.copy_offset;
  assign out_o.end_ok       = res.end_ok;
  assign out_o.run_last     = res.run_last;

endmodule

### tb/tb_diff_command_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Diff command stream decoder testbench
// Drives diff scripts into the decoder one byte per transfer and predicts the
// literal, copy and end results of every byte with a behavioral parser. Short
// directed scripts cover the commands and their corner cases. Generated
// scripts follow with random lengths, offsets and literals, mixed with broken
// and overflowing scripts and noise. The phases vary sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_diff_command_stream_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;

  dcsd_in_if  in_ch();
  dcsd_out_if out_ch();

  diff_command_stream_decoder_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  dcsd_pkg::mode_e dec_mode;
  logic [31:0]     len_cnt;
  logic [31:0]     off_cnt;
  dcsd_pkg::res_t  pending_results[$];
  logic [7:0]      script_bytes[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned error_count;
  int unsigned decoded_bytes;
  int unsigned script_count;
  int unsigned literal_count;
  int unsigned copy_count;
  int unsigned clean_end_count;
  int unsigned bad_end_count;

  function automatic bit accumulate_digit(inout logic [31:0] acc, input logic [3:0] d);
    logic [63:0] lim;
    lim = (64'd1 << dcsd_pkg::EffWidth) - 64'd1;
    if ({32'b0, acc} > (lim - {60'b0, d}) / 64'd10) return 1'b0;
    acc = acc * 32'd10 + {28'b0, d};
    return 1'b1;
  endfunction

  function automatic bit start_command(input logic [7:0] b);
    if (b == dcsd_pkg::ChA) begin
      len_cnt  = '0;
      dec_mode = dcsd_pkg::ModeALen;
    end else if (b == dcsd_pkg::ChC) begin
      len_cnt  = '0;
      off_cnt  = '0;
      dec_mode = dcsd_pkg::ModeCLen;
    end else if (b != dcsd_pkg::ChLf && b != dcsd_pkg::ChCr) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_result(input logic [1:0] kind, input logic [7:0] lit,
                             input logic [31:0] len, input logic [31:0] off,
                             input logic ok);
    dcsd_pkg::res_t r;
    r = '0;
    r.result_kind  = kind;
    r.literal_byte = lit;
    r.copy_length  = len;
    r.copy_offset  = off;
    r.end_ok       = ok;
    pending_results.push_back(r);
  endtask

  task automatic decode_script_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  dv;
    logic        is_digit;
    logic        bad;
    logic        ok;
    int unsigned first;
    first    = pending_results.size();
    dv       = b - dcsd_pkg::ChZero;
    is_digit = (b >= dcsd_pkg::ChZero) && (b <= dcsd_pkg::ChNine);
    bad      = 1'b0;
    if (dec_mode == dcsd_pkg::ModeDiscard) begin
      if (fin) dec_mode = dcsd_pkg::ModeIdle;
      return;
    end
    decoded_bytes++;
    case (dec_mode)
      dcsd_pkg::ModeALen: begin
        if (is_digit) begin
          bad = !accumulate_digit(len_cnt, dv[3:0]);
        end else if (b == dcsd_pkg::ChColon) begin
          if (len_cnt == 0) dec_mode = dcsd_pkg::ModeIdle;
          else dec_mode = dcsd_pkg::ModeAData;
        end else begin
          bad = 1'b1;
        end
      end
      dcsd_pkg::ModeAData: begin
        note_result(dcsd_pkg::KindLiteral, b, '0, '0, 1'b0);
        len_cnt = len_cnt - 32'd1;
        if (len_cnt == 0) dec_mode = dcsd_pkg::ModeIdle;
      end
      dcsd_pkg::ModeCLen: begin
        if (is_digit) begin
          bad = !accumulate_digit(len_cnt, dv[3:0]);
        end else if (b == dcsd_pkg::ChComma) begin
          off_cnt  = '0;
          dec_mode = dcsd_pkg::ModeCOff;
        end else begin
          bad = 1'b1;
        end
      end
      dcsd_pkg::ModeCOff: begin
        if (is_digit) begin
          bad = !accumulate_digit(off_cnt, dv[3:0]);
        end else begin
          note_result(dcsd_pkg::KindCopy, '0, len_cnt, off_cnt, 1'b0);
          dec_mode = dcsd_pkg::ModeIdle;
          bad      = start_command(b);
        end
      end
      default: begin
        dec_mode = dcsd_pkg::ModeIdle;
        bad      = start_command(b);
      end
    endcase
    if (bad) begin
      note_result(dcsd_pkg::KindEnd, '0, '0, '0, 1'b0);
      dec_mode = fin ? dcsd_pkg::ModeIdle : dcsd_pkg::ModeDiscard;
      len_cnt  = '0;
      off_cnt  = '0;
    end else if (fin) begin
      ok = 1'b0;
      if (dec_mode == dcsd_pkg::ModeCOff) begin
        note_result(dcsd_pkg::KindCopy, '0, len_cnt, off_cnt, 1'b0);
        ok = 1'b1;
      end else if (dec_mode == dcsd_pkg::ModeIdle) begin
        ok = 1'b1;
      end
      note_result(dcsd_pkg::KindEnd, '0, '0, '0, ok);
      dec_mode = dcsd_pkg::ModeIdle;
      len_cnt  = '0;
      off_cnt  = '0;
    end
    if (pending_results.size() > first)
      pending_results[pending_results.size() - 1].run_last = 1'b1;
  endtask

  task automatic check_result(input dcsd_pkg::res_t got);
    dcsd_pkg::res_t want;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("Unexpected result: kind=%0d lit=%0h len=%0d off=%0d ok=%0d last=%0d",
                 got.result_kind, got.literal_byte, got.copy_length, got.copy_offset,
                 got.end_ok, got.run_last);
      return;
    end
    want = pending_results.pop_front();
    case (want.result_kind)
      dcsd_pkg::KindLiteral: literal_count++;
      dcsd_pkg::KindCopy:    copy_count++;
      default: begin
        if (want.end_ok) clean_end_count++;
        else bad_end_count++;
      end
    endcase
    if (got.result_kind !== want.result_kind || got.literal_byte !== want.literal_byte ||
        got.copy_length !== want.copy_length || got.copy_offset !== want.copy_offset ||
        got.end_ok !== want.end_ok || got.run_last !== want.run_last) begin
      error_count++;
      if (error_count <= 10) begin
        $display("Mismatch at %0t ns:", $realtime);
        $display("  expected kind=%0d lit=%0h len=%0d off=%0d ok=%0d last=%0d",
                 want.result_kind, want.literal_byte, want.copy_length, want.copy_offset,
                 want.end_ok, want.run_last);
        $display("  actual   kind=%0d lit=%0h len=%0d off=%0d ok=%0d last=%0d",
                 got.result_kind, got.literal_byte, got.copy_length, got.copy_offset,
                 got.end_ok, got.run_last);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Handshake signals only change at rising edges, so the falling edge sees
  // exactly what the next rising edge will accept.
  always @(negedge clk) begin
    dcsd_pkg::res_t got;
    got.result_kind  = out_ch.result_kind;
    got.literal_byte = out_ch.literal_byte;
    got.copy_length  = out_ch.copy_length;
    got.copy_offset  = out_ch.copy_offset;
    got.end_ok       = out_ch.end_ok;
    got.run_last     = out_ch.run_last;
    if (rst_n && out_ch.valid && out_ch.ready) check_result(got);
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.script_byte <= b;
    in_ch.final_byte  <= fin;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    decode_script_byte(b, fin);
  endtask

  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) script_bytes.push_back(s[i]);
  endtask

  task automatic append_number(input int unsigned style);
    case (style)
      0: append_text("");
      1: append_text($sformatf("%0d", $urandom_range(9)));
      2: append_text($sformatf("%0d", $urandom_range(999)));
      3: append_text($sformatf("%0d", $urandom));
      4: append_text("4294967295");
      5: append_text($sformatf("00%0d", $urandom_range(99)));
      default: append_text($sformatf("%0d%0d", $urandom_range(32'hFFFF_FFFF, 32'h1999_9999),
                                     $urandom_range(9)));
    endcase
  endtask

  task automatic build_script();
    int unsigned len;
    int unsigned pos;
    script_bytes.delete();
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(3) == 0)
        script_bytes.push_back($urandom_range(1) ? dcsd_pkg::ChLf : dcsd_pkg::ChCr);
      if ($urandom_range(1)) begin
        len = $urandom_range(8);
        script_bytes.push_back(dcsd_pkg::ChA);
        if (len != 0 || $urandom_range(1)) append_text($sformatf("%0d", len));
        script_bytes.push_back(dcsd_pkg::ChColon);
        repeat (len) script_bytes.push_back(8'($urandom_range(255)));
      end else begin
        script_bytes.push_back(dcsd_pkg::ChC);
        append_number($urandom_range(5));
        script_bytes.push_back(dcsd_pkg::ChComma);
        append_number($urandom_range(5));
      end
    end
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: begin
          len = $urandom_range(script_bytes.size() - 1);
          repeat (len) void'(script_bytes.pop_back());
        end
        1: begin
          pos = $urandom_range(script_bytes.size() - 1);
          script_bytes[pos] = 8'($urandom_range(255));
        end
        2: begin
          script_bytes.push_back($urandom_range(1) ? dcsd_pkg::ChA : dcsd_pkg::ChC);
          if ($urandom_range(1)) begin
            append_number(1);
            script_bytes.push_back(dcsd_pkg::ChComma);
          end
          append_number(6);
          if ($urandom_range(1)) script_bytes.push_back(dcsd_pkg::ChLf);
        end
        default: begin
          script_bytes.delete();
          repeat ($urandom_range(8, 1)) script_bytes.push_back(8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  task automatic send_script();
    script_count++;
    foreach (script_bytes[i]) send_byte(script_bytes[i], i == script_bytes.size() - 1);
  endtask

  task automatic test_add_commands();
    send_text("A0:A2:", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("A5", 1'b1);
  endtask

  task automatic test_copy_commands();
    send_text("C,\rC3,", 1'b1);
    send_text("C1,2Q", 1'b1);
    send_text("\nC7,9", 1'b1);
  endtask

  task automatic test_malformed_bytes();
    send_text("X", 1'b0);
    send_text("Y", 1'b1);
    send_text("A1Z\n", 1'b1);
  endtask

  task automatic test_count_overflow();
    send_text("C4294967295,7", 1'b1);
    send_text("A4294967296x", 1'b1);
  endtask

  task automatic test_random_scripts(input int unsigned target);
    int unsigned base;
    int unsigned seg;
    base = decoded_bytes;
    for (seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      while (decoded_bytes - base < target * (seg + 1) / 8) begin
        build_script();
        send_script();
      end
      wait_for_drain();
    end
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.script_byte <= '0;
    in_ch.final_byte  <= 1'b0;
    rst_n = 1'b0;
    dec_mode = dcsd_pkg::ModeIdle;
    len_cnt  = '0;
    off_cnt  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    error_count     = 0;
    decoded_bytes   = 0;
    script_count    = 0;
    literal_count   = 0;
    copy_count      = 0;
    clean_end_count = 0;
    bad_end_count   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_commands();
    test_copy_commands();
    test_malformed_bytes();
    test_count_overflow();
    wait_for_drain();
    test_random_scripts(1500);
    wait_for_drain();
    repeat (10) @(posedge clk);
    error_count += pending_results.size();
    $display("Decoded %0d bytes in %0d generated scripts plus directed cases.",
             decoded_bytes, script_count);
    $display("Checked %0d literals, %0d copies, %0d clean ends and %0d malformed ends.",
             literal_count, copy_count, clean_end_count, bad_end_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

### diff_command_stream_decoder_top.f
rtl/core/dcsd_pkg.sv
rtl/core/dcsd_if.sv
rtl/core/dcsd_parser.sv
rtl/core/dcsd_queue.sv
rtl/core/diff_command_stream_decoder_top.sv
tb/tb_diff_command_stream_decoder_top.sv
